/* src/hlc_pkg.sv */
package hlc_pkg;

    localparam int PARAM_FRAC_BITS_DEF = 16;

    // Width of the plane numerator and denominator, and of their magnitudes.
    localparam int PLANE_W = 35;
    localparam int NUM_PLANES = 6;

    localparam logic [1:0] ST_INSIDE   = 2'd0;
    localparam logic [1:0] ST_TRIV_REJ = 2'd1;
    localparam logic [1:0] ST_CLIPPED  = 2'd2;
    localparam logic [1:0] ST_CLIP_REJ = 2'd3;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] start_w;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic signed [31:0] end_w;
        logic [5:0]         start_code;
        logic [5:0]         end_code;
        logic [31:0]        start_color;
        logic [31:0]        end_color;
    } hlc_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_start_x;
        logic signed [31:0] out_start_y;
        logic signed [31:0] out_start_z;
        logic signed [31:0] out_start_w;
        logic signed [31:0] out_end_x;
        logic signed [31:0] out_end_y;
        logic signed [31:0] out_end_z;
        logic signed [31:0] out_end_w;
        logic [31:0]        out_start_color;
        logic [31:0]        out_end_color;
    } hlc_out_t;

    // Pipeline control that travels with each word.
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
    } hlc_ctl_t;

    // Per-plane flags settled before the division.
    typedef struct packed {
        logic pos;
        logic zero;
        logic prej;
        logic tneg;
        logic sat;
    } hlc_pflag_t;

endpackage

/* src/hlc_setup.sv */
module hlc_setup #(
    parameter int PARAM_FRAC_BITS = hlc_pkg::PARAM_FRAC_BITS_DEF,
    parameter int REM_W = hlc_pkg::PLANE_W + 2 + PARAM_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  hlc_pkg::hlc_in_t                   segment,
    output hlc_pkg::hlc_ctl_t                  ctl,
    output hlc_pkg::hlc_in_t                   seg,
    output logic [REM_W-1:0]                   rem   [hlc_pkg::NUM_PLANES],
    output logic [hlc_pkg::PLANE_W-1:0]        dmag  [hlc_pkg::NUM_PLANES],
    output hlc_pkg::hlc_pflag_t                pflag [hlc_pkg::NUM_PLANES]
);
    import hlc_pkg::*;

    hlc_ctl_t                  ctl1_reg, ctl1_next, ctl2_reg;
    hlc_in_t                   seg1_reg, seg2_reg;
    logic signed [PLANE_W-1:0] num_reg [NUM_PLANES];
    logic signed [PLANE_W-1:0] den_reg [NUM_PLANES];
    logic signed [PLANE_W-1:0] num_next [NUM_PLANES];
    logic signed [PLANE_W-1:0] den_next [NUM_PLANES];
    logic [REM_W-1:0]          rem_reg [NUM_PLANES];
    logic [REM_W-1:0]          rem_next [NUM_PLANES];
    logic [PLANE_W-1:0]        dmag_reg [NUM_PLANES];
    logic [PLANE_W-1:0]        dmag_next [NUM_PLANES];
    hlc_pflag_t                pf_reg [NUM_PLANES];
    hlc_pflag_t                pf_next [NUM_PLANES];

    // First stage: plane numerators and denominators, and the outcode class.
    always_comb
    begin
        logic signed [PLANE_W-1:0] a [4];
        logic signed [PLANE_W-1:0] b [4];
        a[0] = PLANE_W'(segment.start_x);
        a[1] = PLANE_W'(segment.start_y);
        a[2] = PLANE_W'(segment.start_z);
        a[3] = PLANE_W'(segment.start_w);
        b[0] = PLANE_W'(segment.end_x);
        b[1] = PLANE_W'(segment.end_y);
        b[2] = PLANE_W'(segment.end_z);
        b[3] = PLANE_W'(segment.end_w);
        for (int j = 0; j < NUM_PLANES; j++)
        begin
            if (j % 2 == 0)
            begin
                num_next[j] = -a[j / 2] - a[3];
                den_next[j] = (b[j / 2] - a[j / 2]) + (b[3] - a[3]);
            end
            else
            begin
                num_next[j] = a[j / 2] - a[3];
                den_next[j] = (a[j / 2] - b[j / 2]) + (b[3] - a[3]);
            end
        end
        ctl1_next.valid = start;
        if ((segment.start_code | segment.end_code) == 6'd0)
            ctl1_next.kind = ST_INSIDE;
        else if ((segment.start_code & segment.end_code) != 6'd0)
            ctl1_next.kind = ST_TRIV_REJ;
        else
            ctl1_next.kind = ST_CLIPPED;
    end

    // Second stage: magnitudes, signs and the early quotient overflow test.
    always_comb
    begin
        logic [PLANE_W-1:0] nmag;
        for (int j = 0; j < NUM_PLANES; j++)
        begin
            nmag = num_reg[j][PLANE_W-1] ? PLANE_W'(-num_reg[j]) : PLANE_W'(num_reg[j]);
            dmag_next[j] = den_reg[j][PLANE_W-1] ? PLANE_W'(-den_reg[j])
                                                 : PLANE_W'(den_reg[j]);
            pf_next[j].pos  = !den_reg[j][PLANE_W-1] && (den_reg[j] != '0);
            pf_next[j].zero = (den_reg[j] == '0);
            pf_next[j].prej = (den_reg[j] == '0) && !num_reg[j][PLANE_W-1]
                              && (num_reg[j] != '0);
            pf_next[j].tneg = num_reg[j][PLANE_W-1] ^ den_reg[j][PLANE_W-1];
            pf_next[j].sat  = ((PLANE_W + 2)'(nmag)) >= {dmag_next[j], 2'b00};
            rem_next[j] = REM_W'(nmag) << PARAM_FRAC_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        seg1_reg <= segment;
        seg2_reg <= seg1_reg;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        pf_reg   <= pf_next;
    end

    assign ctl   = ctl2_reg;
    assign seg   = seg2_reg;
    assign rem   = rem_reg;
    assign dmag  = dmag_reg;
    assign pflag = pf_reg;

endmodule

/* src/hlc_div_step.sv */
module hlc_div_step #(
    parameter int PARAM_FRAC_BITS = hlc_pkg::PARAM_FRAC_BITS_DEF,
    parameter int REM_W = hlc_pkg::PLANE_W + 2 + PARAM_FRAC_BITS,
    parameter int BIT = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hlc_pkg::hlc_ctl_t           ctl_in,
    input  hlc_pkg::hlc_in_t            seg_in,
    input  logic [REM_W-1:0]            rem_in   [hlc_pkg::NUM_PLANES],
    input  logic [hlc_pkg::PLANE_W-1:0] dmag_in  [hlc_pkg::NUM_PLANES],
    input  hlc_pkg::hlc_pflag_t         pf_in    [hlc_pkg::NUM_PLANES],
    input  logic [PARAM_FRAC_BITS+1:0]  q_in     [hlc_pkg::NUM_PLANES],
    output hlc_pkg::hlc_ctl_t           ctl_out,
    output hlc_pkg::hlc_in_t            seg_out,
    output logic [REM_W-1:0]            rem_out  [hlc_pkg::NUM_PLANES],
    output logic [hlc_pkg::PLANE_W-1:0] dmag_out [hlc_pkg::NUM_PLANES],
    output hlc_pkg::hlc_pflag_t         pf_out   [hlc_pkg::NUM_PLANES],
    output logic [PARAM_FRAC_BITS+1:0]  q_out    [hlc_pkg::NUM_PLANES]
);
    import hlc_pkg::*;

    localparam int Q_W = PARAM_FRAC_BITS + 2;

    hlc_ctl_t           ctl_reg;
    hlc_in_t            seg_reg;
    logic [REM_W-1:0]   rem_reg [NUM_PLANES];
    logic [REM_W-1:0]   rem_next [NUM_PLANES];
    logic [PLANE_W-1:0] dmag_reg [NUM_PLANES];
    hlc_pflag_t         pf_reg [NUM_PLANES];
    logic [Q_W-1:0]     q_reg [NUM_PLANES];
    logic [Q_W-1:0]     q_next [NUM_PLANES];

    // One restoring quotient bit per plane.
    always_comb
    begin
        logic [REM_W-1:0] trial;
        for (int j = 0; j < NUM_PLANES; j++)
        begin
            trial = REM_W'(dmag_in[j]) << BIT;
            q_next[j] = q_in[j];
            rem_next[j] = rem_in[j];
            if (rem_in[j] >= trial)
            begin
                rem_next[j] = rem_in[j] - trial;
                q_next[j][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        seg_reg  <= seg_in;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_in;
        pf_reg   <= pf_in;
        q_reg    <= q_next;
    end

    assign ctl_out  = ctl_reg;
    assign seg_out  = seg_reg;
    assign rem_out  = rem_reg;
    assign dmag_out = dmag_reg;
    assign pf_out   = pf_reg;
    assign q_out    = q_reg;

endmodule

/* src/hlc_narrow.sv */
module hlc_narrow #(
    parameter int PARAM_FRAC_BITS = hlc_pkg::PARAM_FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  hlc_pkg::hlc_ctl_t          ctl_in,
    input  hlc_pkg::hlc_in_t           seg_in,
    input  hlc_pkg::hlc_pflag_t        pf_in [hlc_pkg::NUM_PLANES],
    input  logic [PARAM_FRAC_BITS+1:0] q_in  [hlc_pkg::NUM_PLANES],
    output hlc_pkg::hlc_ctl_t          ctl_out,
    output hlc_pkg::hlc_in_t           seg_out,
    output logic [1:0]                 status,
    output logic [PARAM_FRAC_BITS:0]   tmin,
    output logic [PARAM_FRAC_BITS:0]   tmax
);
    import hlc_pkg::*;

    localparam int T_W = PARAM_FRAC_BITS + 3;
    localparam logic [T_W-1:0] ONE_T = T_W'(1) << PARAM_FRAC_BITS;
    // Any quotient above one behaves as one plus an ulp in the range tests.
    localparam logic [T_W-1:0] T_BIG = ONE_T + T_W'(1);

    hlc_ctl_t                   ctl_reg;
    hlc_in_t                    seg_reg;
    logic [1:0]                 status_reg, status_next;
    logic [PARAM_FRAC_BITS:0]   tmin_reg, tmin_next, tmax_reg, tmax_next;

    always_comb
    begin
        logic [T_W-1:0]        mq;
        logic signed [T_W-1:0] t;
        logic signed [T_W-1:0] lo;
        logic signed [T_W-1:0] hi;
        logic                  ok;
        lo = '0;
        hi = $signed(ONE_T);
        ok = 1'b1;
        for (int j = 0; j < NUM_PLANES; j++)
        begin
            mq = T_W'(q_in[j]);
            if (pf_in[j].sat || (mq > T_BIG))
                mq = T_BIG;
            t = pf_in[j].tneg ? -$signed(mq) : $signed(mq);
            if (ok)
            begin
                if (pf_in[j].zero)
                begin
                    if (pf_in[j].prej)
                        ok = 1'b0;
                end
                else if (pf_in[j].pos)
                begin
                    if (t > hi)
                        ok = 1'b0;
                    else if (t > lo)
                        lo = t;
                end
                else
                begin
                    if (t < lo)
                        ok = 1'b0;
                    else if (t < hi)
                        hi = t;
                end
            end
        end
        tmin_next = lo[PARAM_FRAC_BITS:0];
        tmax_next = hi[PARAM_FRAC_BITS:0];
        case (ctl_in.kind)
            ST_INSIDE:   status_next = ST_INSIDE;
            ST_TRIV_REJ: status_next = ST_TRIV_REJ;
            default:     status_next = ok ? ST_CLIPPED : ST_CLIP_REJ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        seg_reg    <= seg_in;
        status_reg <= status_next;
        tmin_reg   <= tmin_next;
        tmax_reg   <= tmax_next;
    end

    assign ctl_out = ctl_reg;
    assign seg_out = seg_reg;
    assign status  = status_reg;
    assign tmin    = tmin_reg;
    assign tmax    = tmax_reg;

endmodule

/* src/hlc_interp.sv */
module hlc_interp #(
    parameter int PARAM_FRAC_BITS = hlc_pkg::PARAM_FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hlc_pkg::hlc_ctl_t        ctl_in,
    input  hlc_pkg::hlc_in_t         seg_in,
    input  logic [1:0]               status_in,
    input  logic [PARAM_FRAC_BITS:0] tmin,
    input  logic [PARAM_FRAC_BITS:0] tmax,
    output logic                     done,
    output hlc_pkg::hlc_out_t        result
);
    import hlc_pkg::*;

    localparam int TS_W = PARAM_FRAC_BITS + 2;
    localparam int CP_W = 33 + TS_W;
    localparam int KP_W = 9 + TS_W;
    localparam logic [CP_W-1:0] HALF_C = CP_W'(1) << (PARAM_FRAC_BITS - 1);
    localparam logic [KP_W-1:0] HALF_K = KP_W'(1) << (PARAM_FRAC_BITS - 1);

    hlc_ctl_t                ctl_reg;
    hlc_in_t                 seg_reg;
    logic [1:0]              status_reg;
    logic signed [CP_W-1:0]  cp_reg [2][4];
    logic signed [CP_W-1:0]  cp_next [2][4];
    logic signed [KP_W-1:0]  kp_reg [2][4];
    logic signed [KP_W-1:0]  kp_next [2][4];
    logic                    done_reg;
    hlc_out_t                result_reg, result_next;

    // Multiply stage: coordinate and channel deltas times tmin and tmax.
    always_comb
    begin
        logic signed [31:0]     a [4];
        logic signed [31:0]     b [4];
        logic signed [32:0]     d;
        logic signed [8:0]      dc;
        logic signed [TS_W-1:0] t [2];
        a[0] = seg_in.start_x; a[1] = seg_in.start_y;
        a[2] = seg_in.start_z; a[3] = seg_in.start_w;
        b[0] = seg_in.end_x;   b[1] = seg_in.end_y;
        b[2] = seg_in.end_z;   b[3] = seg_in.end_w;
        t[0] = $signed({1'b0, tmin});
        t[1] = $signed({1'b0, tmax});
        for (int e = 0; e < 2; e++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                d = 33'(b[i]) - 33'(a[i]);
                cp_next[e][i] = CP_W'(d) * CP_W'(t[e]);
                dc = $signed({1'b0, seg_in.end_color[8*i +: 8]})
                   - $signed({1'b0, seg_in.start_color[8*i +: 8]});
                kp_next[e][i] = KP_W'(dc) * KP_W'(t[e]);
            end
        end
    end

    // Rounding stage: round half up, add to the start value, select by status.
    always_comb
    begin
        logic signed [31:0]    a [4];
        logic signed [31:0]    v [2][4];
        logic [7:0]            c [2][4];
        logic signed [CP_W-1:0] pc;
        logic signed [KP_W-1:0] pk;
        a[0] = seg_reg.start_x; a[1] = seg_reg.start_y;
        a[2] = seg_reg.start_z; a[3] = seg_reg.start_w;
        for (int e = 0; e < 2; e++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pc = (cp_reg[e][i] + $signed(HALF_C)) >>> PARAM_FRAC_BITS;
                v[e][i] = a[i] + pc[31:0];
                pk = (kp_reg[e][i] + $signed(HALF_K)) >>> PARAM_FRAC_BITS;
                c[e][i] = seg_reg.start_color[8*i +: 8] + pk[7:0];
            end
        end
        result_next = '0;
        result_next.status = status_reg;
        case (status_reg)
            ST_INSIDE:
            begin
                result_next.out_start_x     = seg_reg.start_x;
                result_next.out_start_y     = seg_reg.start_y;
                result_next.out_start_z     = seg_reg.start_z;
                result_next.out_start_w     = seg_reg.start_w;
                result_next.out_end_x       = seg_reg.end_x;
                result_next.out_end_y       = seg_reg.end_y;
                result_next.out_end_z       = seg_reg.end_z;
                result_next.out_end_w       = seg_reg.end_w;
                result_next.out_start_color = seg_reg.start_color;
                result_next.out_end_color   = seg_reg.end_color;
            end
            ST_CLIPPED:
            begin
                result_next.out_start_x     = v[0][0];
                result_next.out_start_y     = v[0][1];
                result_next.out_start_z     = v[0][2];
                result_next.out_start_w     = v[0][3];
                result_next.out_end_x       = v[1][0];
                result_next.out_end_y       = v[1][1];
                result_next.out_end_z       = v[1][2];
                result_next.out_end_w       = v[1][3];
                result_next.out_start_color = {c[0][3], c[0][2], c[0][1], c[0][0]};
                result_next.out_end_color   = {c[1][3], c[1][2], c[1][1], c[1][0]};
            end
            default:
            begin
                result_next.status = status_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl_in;
            done_reg <= ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg    <= seg_in;
        status_reg <= status_in;
        cp_reg     <= cp_next;
        kp_reg     <= kp_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* src/homogeneous_line_clipper.sv */
// Homogeneous line clipper: clips one segment per word against the six
// clip-space planes -w <= x, y, z <= w, Liang-Barsky style, in fixed point.
//
// Input channel: the caller drives segment and raises start for one cycle
// per word. A word is taken at every rising edge with start high and busy
// low. busy is always low here, so a new word can enter on every cycle.
//
// Output channel: done is high for exactly one cycle per word, with the
// result on result in that same cycle. The receiver cannot stall the block;
// it has to take each result as it appears. Results leave in input order.
//
// The throughput is one word per cycle. The six parallel dividers for the
// plane parameters resolve one quotient bit per pipeline stage over
// PARAM_FRAC_BITS + 2 stages. Before them sit two setup stages, after them
// one stage that narrows the parameter range across the planes, a multiply
// stage and the rounding and output register.
//
// Reset clears all valid bits, so no stray done pulse follows reset.
module homogeneous_line_clipper #(
    parameter int PARAM_FRAC_BITS = hlc_pkg::PARAM_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  hlc_pkg::hlc_in_t  segment,
    output logic              done,
    output hlc_pkg::hlc_out_t result
);
    import hlc_pkg::*;

    localparam int REM_W = PLANE_W + 2 + PARAM_FRAC_BITS;
    localparam int Q_W = PARAM_FRAC_BITS + 2;
    localparam int N_DIV = PARAM_FRAC_BITS + 2;
    localparam int LATENCY = PARAM_FRAC_BITS + 7;

    // Stage index s carries the word before quotient step s; index N_DIV
    // holds the finished quotients.
    hlc_ctl_t           ctl_s  [N_DIV+1];
    hlc_in_t            seg_s  [N_DIV+1];
    logic [REM_W-1:0]   rem_s  [N_DIV+1][NUM_PLANES];
    logic [PLANE_W-1:0] dmag_s [N_DIV+1][NUM_PLANES];
    hlc_pflag_t         pf_s   [N_DIV+1][NUM_PLANES];
    logic [Q_W-1:0]     q_s    [N_DIV+1][NUM_PLANES];

    hlc_ctl_t                 ctl_n;
    hlc_in_t                  seg_n;
    logic [1:0]               status_n;
    logic [PARAM_FRAC_BITS:0] tmin_n;
    logic [PARAM_FRAC_BITS:0] tmax_n;

    // The pipeline never stalls, so the input side is always open.
    assign busy = 1'b0;

    hlc_setup #(
        .PARAM_FRAC_BITS(PARAM_FRAC_BITS),
        .REM_W(REM_W)
    ) u_setup (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .segment(segment),
        .ctl(ctl_s[0]),
        .seg(seg_s[0]),
        .rem(rem_s[0]),
        .dmag(dmag_s[0]),
        .pflag(pf_s[0])
    );

    always_comb
    begin
        for (int j = 0; j < NUM_PLANES; j++)
            q_s[0][j] = '0;
    end

    // The quotient is at most PARAM_FRAC_BITS + 2 bits wide once the setup
    // stage has flagged numerators of four or more times the denominator.
    for (genvar s = 0; s < N_DIV; s++)
    begin : g_div
        hlc_div_step #(
            .PARAM_FRAC_BITS(PARAM_FRAC_BITS),
            .REM_W(REM_W),
            .BIT(N_DIV - 1 - s)
        ) u_step (
            .clk(clk),
            .rst_n(rst_n),
            .ctl_in(ctl_s[s]),
            .seg_in(seg_s[s]),
            .rem_in(rem_s[s]),
            .dmag_in(dmag_s[s]),
            .pf_in(pf_s[s]),
            .q_in(q_s[s]),
            .ctl_out(ctl_s[s+1]),
            .seg_out(seg_s[s+1]),
            .rem_out(rem_s[s+1]),
            .dmag_out(dmag_s[s+1]),
            .pf_out(pf_s[s+1]),
            .q_out(q_s[s+1])
        );
    end

    hlc_narrow #(
        .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
    ) u_narrow (
        .clk(clk),
        .rst_n(rst_n),
        .ctl_in(ctl_s[N_DIV]),
        .seg_in(seg_s[N_DIV]),
        .pf_in(pf_s[N_DIV]),
        .q_in(q_s[N_DIV]),
        .ctl_out(ctl_n),
        .seg_out(seg_n),
        .status(status_n),
        .tmin(tmin_n),
        .tmax(tmax_n)
    );

    hlc_interp #(
        .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
    ) u_interp (
        .clk(clk),
        .rst_n(rst_n),
        .ctl_in(ctl_n),
        .seg_in(seg_n),
        .status_in(status_n),
        .tmin(tmin_n),
        .tmax(tmax_n),
        .done(done),
        .result(result)
    );

    // Every result comes from an accepted word.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
    else $error("result without a matching accepted word");

    // The narrowed range never inverts for a visible segment.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_n.valid && status_n == ST_CLIPPED) |-> (tmin_n <= tmax_n))
    else $error("clipped range inverted");

    // Rejected results carry zero geometry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_TRIV_REJ || result.status == ST_CLIP_REJ))
        |-> (result.out_start_x == '0 && result.out_end_w == '0
             && result.out_start_color == '0 && result.out_end_color == '0))
    else $error("rejected result has nonzero fields");

    // Outcodes with no bit set always pass through unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_n.valid && ctl_n.kind == ST_INSIDE) |-> (status_n == ST_INSIDE))
    else $error("inside segment lost its status");

endmodule
